@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/rlp_pkg.sv @@
// Types and constants for the radix literal parser.
// No dependencies; used by radix_literal_parser_core.
package rlp_pkg;

  localparam int MAX_DIGITS = 11;
  localparam int ACC_W      = 48;
  localparam int VALUE_W    = 45;
  localparam int CNT_W      = 4;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;

  // The one kind code that names no radix; it is parsed as decimal.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    RADIX_OCT = 2'd0,
    RADIX_DEC = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  typedef enum logic [3:0] {
    PH_PREFIX = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_SPACE  = 4'b1000
  } phase_t;

endpackage

@@ src/radix_literal_parser_core.sv @@
// Channel | Handshake              | Payload
// in      | in_valid / in_stall    | ch, kind, first, last
// out     | out_valid / out_stall  | value, bad_literal, sticky_error
//
// One character is taken per cycle while in_stall is low; the parse state updates in the same edge.
// The character marked last loads the result register, which is shown in the next cycle.
// in_stall rises only while a result waits in the output register and is stalled.
// Reset (rst, synchronous) returns the parser to the prefix phase and clears flags.
// Depends on rlp_pkg.
module radix_literal_parser_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       ch,
  input  logic [1:0]                       kind,
  input  logic                             first,
  input  logic                             last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [rlp_pkg::VALUE_W-1:0] value,
  output logic                             bad_literal,
  output logic                             sticky_error
);

  rlp_pkg::phase_t                phase, phase_next;
  rlp_pkg::radix_t                radix_held, radix_next;
  logic [rlp_pkg::ACC_W-1:0]      accumulator, accumulator_next;
  logic [rlp_pkg::CNT_W-1:0]      digit_count, digit_count_next;
  logic                           is_negative, is_negative_next;
  logic                           literal_error, literal_error_next;
  logic                           error_seen, error_seen_next;
  logic [rlp_pkg::VALUE_W-1:0]    value_next;

  logic       start;
  logic       take;
  logic       is_space;
  logic       dig_ok;
  logic [3:0] dig_val;
  logic       accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;
  assign is_space = (ch == rlp_pkg::CH_SPACE) || (ch == rlp_pkg::CH_TAB);
  assign start    = first || (phase == rlp_pkg::PH_PREFIX);

  always_comb begin
    radix_next = radix_held;
    if (start) begin
      radix_next = (kind == rlp_pkg::KIND_UNUSED) ? rlp_pkg::RADIX_DEC
                                                  : rlp_pkg::radix_t'(kind);
    end
  end

  // Digit decode against the radix in force for this character.
  always_comb begin
    dig_ok  = 1'b0;
    dig_val = 4'd0;
    if (ch inside {[rlp_pkg::CH_ZERO:rlp_pkg::CH_NINE]}) begin
      dig_val = 4'(ch - rlp_pkg::CH_ZERO);
      dig_ok  = !((radix_next == rlp_pkg::RADIX_OCT) && (ch > rlp_pkg::CH_SEVEN));
    end else if (radix_next == rlp_pkg::RADIX_HEX) begin
      if (ch inside {[rlp_pkg::CH_UC_A:rlp_pkg::CH_UC_F]}) begin
        dig_val = 4'(ch - rlp_pkg::CH_UC_A + 8'd10);
        dig_ok  = 1'b1;
      end else if (ch inside {[rlp_pkg::CH_LC_A:rlp_pkg::CH_LC_F]}) begin
        dig_val = 4'(ch - rlp_pkg::CH_LC_A + 8'd10);
        dig_ok  = 1'b1;
      end
    end
  end

  always_comb begin
    phase_next         = phase;
    accumulator_next   = accumulator;
    digit_count_next   = digit_count;
    is_negative_next   = is_negative;
    literal_error_next = literal_error;
    error_seen_next    = error_seen;
    take               = 1'b0;

    if (start) begin
      accumulator_next   = '0;
      digit_count_next   = '0;
      is_negative_next   = 1'b0;
      literal_error_next = 1'b0;
      phase_next         = rlp_pkg::PH_DIGITS;
      if (radix_next == rlp_pkg::RADIX_DEC) begin
        if (ch == rlp_pkg::CH_HASH) begin
          phase_next = rlp_pkg::PH_SIGN;
        end else if (ch == rlp_pkg::CH_MINUS) begin
          is_negative_next = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
    end else if (!literal_error) begin
      case (phase)
        rlp_pkg::PH_SIGN: begin
          phase_next = rlp_pkg::PH_DIGITS;
          if (ch == rlp_pkg::CH_MINUS) begin
            is_negative_next = 1'b1;
          end else begin
            take = 1'b1;
          end
        end
        rlp_pkg::PH_DIGITS: begin
          take = 1'b1;
        end
        rlp_pkg::PH_SPACE: begin
          if (!is_space) begin
            literal_error_next = 1'b1;
            error_seen_next    = 1'b1;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end

    if (take) begin
      if (is_space) begin
        phase_next = rlp_pkg::PH_SPACE;
      end else if (!dig_ok || (digit_count_next >= rlp_pkg::CNT_W'(rlp_pkg::MAX_DIGITS))) begin
        literal_error_next = 1'b1;
        error_seen_next    = 1'b1;
      end else begin
        case (radix_next)
          rlp_pkg::RADIX_OCT:
            accumulator_next = (accumulator_next << 3) | rlp_pkg::ACC_W'(dig_val);
          rlp_pkg::RADIX_HEX:
            accumulator_next = (accumulator_next << 4) | rlp_pkg::ACC_W'(dig_val);
          default:
            accumulator_next = (accumulator_next << 3) + (accumulator_next << 1)
                               + rlp_pkg::ACC_W'(dig_val);
        endcase
        digit_count_next = digit_count_next + 1'b1;
      end
    end

    if (last) begin
      phase_next = rlp_pkg::PH_PREFIX;
    end
  end

  always_comb begin
    if (literal_error_next) begin
      value_next = '1;
    end else if (is_negative_next) begin
      value_next = rlp_pkg::VALUE_W'(rlp_pkg::ACC_W'(0) - accumulator_next);
    end else begin
      value_next = accumulator_next[rlp_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= rlp_pkg::PH_PREFIX;
      radix_held    <= rlp_pkg::RADIX_OCT;
      accumulator   <= '0;
      digit_count   <= '0;
      is_negative   <= 1'b0;
      literal_error <= 1'b0;
      error_seen    <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      radix_held    <= radix_next;
      accumulator   <= accumulator_next;
      digit_count   <= digit_count_next;
      is_negative   <= is_negative_next;
      literal_error <= literal_error_next;
      error_seen    <= error_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      value        <= value_next;
      bad_literal  <= literal_error_next;
      sticky_error <= error_seen_next;
    end
  end

endmodule

@@ src/rlp_checker.sv @@
// Port-level checks for radix_literal_parser_core, bound into that module.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rlp_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [7:0]        ch,
  input logic [1:0]        kind,
  input logic              first,
  input logic              last,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [44:0] value,
  input logic              bad_literal,
  input logic              sticky_error
);

  // A stalled result stays put.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(value))

  // Every accepted final character produces a result in the next cycle.
  `ASSERT_NEXT(a_last_gives_result, clk, rst, in_valid && !in_stall && last, out_valid)

  // A failed literal always reports the all-ones value.
  `ASSERT_SAME(a_bad_value, clk, rst, out_valid && bad_literal, value == 45'h1FFF_FFFF_FFFF)

  // The sticky flag covers the current literal's failure.
  `ASSERT_SAME(a_bad_sticky, clk, rst, out_valid && bad_literal, sticky_error)

  // The input side waits only behind a pending result.
  `ASSERT_SAME(a_stall_cause, clk, rst, in_stall, out_valid)

endmodule

bind radix_literal_parser_core rlp_checker u_rlp_checker (.*);
